// File: rtl/core/plist_pkg.sv
// ----------------------------------------------------------------------------
// plist_pkg
// Constants, codes and index helpers for the positional list.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int CAPACITY = 16;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int MW       = 3;
  localparam int PW       = 5;
  localparam int SW       = 2;
  localparam int DW       = 32;
  localparam int CMPW     = (CW > PW) ? CW : PW;

  localparam logic [MW-1:0] M_INS_FRONT = 3'd0;
  localparam logic [MW-1:0] M_INS_END   = 3'd1;
  localparam logic [MW-1:0] M_INS_POS   = 3'd2;
  localparam logic [MW-1:0] M_REM_FRONT = 3'd3;
  localparam logic [MW-1:0] M_REM_END   = 3'd4;
  localparam logic [MW-1:0] M_REM_POS   = 3'd5;

  localparam logic [SW-1:0] ST_OK     = 2'd0;
  localparam logic [SW-1:0] ST_EMPTY  = 2'd1;
  localparam logic [SW-1:0] ST_BADPOS = 2'd2;
  localparam logic [SW-1:0] ST_FULL   = 2'd3;

  // logical index to ring slot
  function automatic logic [AW-1:0] phys_idx(input logic [AW-1:0] h,
                                             input logic [AW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, l};
    if (s >= (AW+1)'(CAPACITY)) s = s - (AW+1)'(CAPACITY);
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] h);
    logic [AW-1:0] r;
    if (h == AW'(CAPACITY - 1)) r = '0;
    else r = h + AW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] h);
    logic [AW-1:0] r;
    if (h == '0) r = AW'(CAPACITY - 1);
    else r = h - AW'(1);
    return r;
  endfunction

endpackage

// File: rtl/core/plist_ram.sv
// ----------------------------------------------------------------------------
// plist_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module plist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/positional_list_insert_remove_top.sv
// ----------------------------------------------------------------------------
// positional_list_insert_remove_top
// Ordered list of signed words held as a ring in one RAM with a head pointer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_stall  | mode, value_in, position
//  out     | out | out_valid/out_stall| value_out, status, entry_count
//
//  Failed ops, no-ops, insert at front or end finish in the idle state.
//  Insert at p (0 < p < count): S_UP moves entries from the tail to p up.
//  Remove at p > 0: S_DOWN moves the entries after p down; a front or end
//  removal only reads p. Shifts go one entry per cycle on one RAM write port.
//  rst is synchronous; it clears count, head and control, not the RAM.
//  in_stall is high while an op runs or while a result beat is held.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [plist_pkg::MW-1:0]          mode,
  input  logic signed [plist_pkg::DW-1:0]   value_in,
  input  logic [plist_pkg::PW-1:0]          position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [plist_pkg::DW-1:0]   value_out,
  output logic [plist_pkg::SW-1:0]          status,
  output logic [plist_pkg::PW-1:0]          entry_count
);

  localparam int AW   = plist_pkg::AW;
  localparam int CW   = plist_pkg::CW;
  localparam int PW   = plist_pkg::PW;
  localparam int DW   = plist_pkg::DW;
  localparam int CMPW = plist_pkg::CMPW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UP   = 2'd1;
  localparam logic [1:0] S_DOWN = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [AW-1:0] head;
  logic [AW-1:0] cur;
  logic [AW-1:0] tgt;
  logic [AW-1:0] last;
  logic [AW-1:0] pend_idx;
  logic          active;
  logic          pend;
  logic          front;
  logic [DW-1:0] val_hold;
  logic [DW-1:0] removed;

  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [DW-1:0] rdata;

  logic            in_acc;
  logic            out_take;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] ins_pos;
  logic [CMPW-1:0] rem_pos;
  logic            is_ins;
  logic            is_rem;
  logic [1:0]      st_dec;
  logic            ins_shift;
  logic            rem_go;
  logic            out_set;

  plist_ram #(.WIDTH(DW), .DEPTH(plist_pkg::CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_take = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign cnt_ext  = CMPW'(count);
  assign pos_ext  = CMPW'(position);

  assign ins_shift = is_ins && st_dec == plist_pkg::ST_OK && ins_pos != '0
                     && ins_pos != cnt_ext;
  assign rem_go    = is_rem && st_dec == plist_pkg::ST_OK;
  assign out_set   = (state == S_IDLE) ? (in_acc && !ins_shift && !rem_go)
                   : ((state == S_UP || state == S_DOWN) && !active && !pend);

  always_comb begin
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    ins_pos = '0;
    rem_pos = '0;
    unique case (mode)
      plist_pkg::M_INS_FRONT: begin
        is_ins = 1'b1;
      end
      plist_pkg::M_INS_END: begin
        is_ins  = 1'b1;
        ins_pos = cnt_ext;
      end
      plist_pkg::M_INS_POS: begin
        is_ins  = 1'b1;
        ins_pos = pos_ext;
      end
      plist_pkg::M_REM_FRONT: begin
        is_rem = 1'b1;
      end
      plist_pkg::M_REM_END: begin
        is_rem  = 1'b1;
        rem_pos = cnt_ext - CMPW'(1);
      end
      plist_pkg::M_REM_POS: begin
        is_rem  = 1'b1;
        rem_pos = pos_ext;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st_dec = plist_pkg::ST_OK;
    if (is_ins) begin
      if (ins_pos > cnt_ext) st_dec = plist_pkg::ST_BADPOS;
      else if (count >= CW'(plist_pkg::CAPACITY)) st_dec = plist_pkg::ST_FULL;
    end else if (is_rem) begin
      if (count == '0) st_dec = plist_pkg::ST_EMPTY;
      else if (rem_pos >= cnt_ext) st_dec = plist_pkg::ST_BADPOS;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = plist_pkg::phys_idx(head, cur);
    unique case (state)
      S_IDLE: begin
        if (in_acc && is_ins && st_dec == plist_pkg::ST_OK) begin
          if (ins_pos == '0) begin
            we    = 1'b1;
            waddr = plist_pkg::idx_dec(head);
            wdata = value_in;
          end else if (ins_pos == cnt_ext) begin
            we    = 1'b1;
            waddr = plist_pkg::phys_idx(head, AW'(count));
            wdata = value_in;
          end
        end
      end
      S_UP: begin
        re = active;
        if (pend) begin
          we    = 1'b1;
          waddr = plist_pkg::phys_idx(head, pend_idx + AW'(1));
          wdata = rdata;
        end else if (!active) begin
          we    = 1'b1;
          waddr = plist_pkg::phys_idx(head, tgt);
          wdata = val_hold;
        end
      end
      S_DOWN: begin
        re = active;
        if (pend && pend_idx != tgt) begin
          we    = 1'b1;
          waddr = plist_pkg::phys_idx(head, pend_idx - AW'(1));
          wdata = rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      active    <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_set) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (ins_shift) begin
              state    <= S_UP;
              cur      <= AW'(count - CW'(1));
              tgt      <= AW'(ins_pos);
              val_hold <= value_in;
              active   <= 1'b1;
              pend     <= 1'b0;
            end else if (rem_go) begin
              state  <= S_DOWN;
              cur    <= AW'(rem_pos);
              tgt    <= AW'(rem_pos);
              last   <= (rem_pos == '0) ? '0 : AW'(count - CW'(1));
              front  <= (rem_pos == '0);
              active <= 1'b1;
              pend   <= 1'b0;
            end else begin
              value_out <= '0;
              status    <= st_dec;
              if (st_dec == plist_pkg::ST_OK && is_ins) begin
                count       <= count + CW'(1);
                entry_count <= PW'(count + CW'(1));
                if (ins_pos == '0) head <= plist_pkg::idx_dec(head);
              end else begin
                entry_count <= PW'(count);
              end
            end
          end
        end
        S_UP: begin
          pend <= active;
          if (active) begin
            pend_idx <= cur;
            if (cur == tgt) active <= 1'b0;
            else cur <= cur - AW'(1);
          end
          if (!active && !pend) begin
            state       <= S_IDLE;
            count       <= count + CW'(1);
            value_out   <= '0;
            status      <= plist_pkg::ST_OK;
            entry_count <= PW'(count + CW'(1));
          end
        end
        S_DOWN: begin
          pend <= active;
          if (pend && pend_idx == tgt) removed <= rdata;
          if (active) begin
            pend_idx <= cur;
            if (cur == last) active <= 1'b0;
            else cur <= cur + AW'(1);
          end
          if (!active && !pend) begin
            state       <= S_IDLE;
            count       <= count - CW'(1);
            if (front) head <= plist_pkg::idx_inc(head);
            value_out   <= removed;
            status      <= plist_pkg::ST_OK;
            entry_count <= PW'(count - CW'(1));
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // count bound
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(plist_pkg::CAPACITY))
    else $error("count above capacity");

  // no result beat is held while a shift runs
  a_busy_no_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP || state == S_DOWN) |-> !out_valid)
    else $error("result pending during shift");

  // a removal never runs on an empty list
  a_down_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_DOWN |-> count != '0)
    else $error("removal on empty list");

  // an insert shift never runs on a full list
  a_up_not_full: assert property (@(posedge clk) disable iff (rst)
    state == S_UP |-> count < CW'(plist_pkg::CAPACITY))
    else $error("insert shift on full list");

  // a finished insert shift raises count by one
  a_shift_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP && !active && !pend) |=> count == $past(count) + CW'(1))
    else $error("insert did not bump count");

endmodule
